### rtl/core/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared widths, codes and reset values for the beep pattern sequencer.
// ----------------------------------------------------------------------------
package bps_pkg;

	// Payload widths
	localparam int KIND_W   = 2;
	localparam int TYPE_W   = 2;
	localparam int COUNT_W  = 8;
	localparam int PHASE_W  = 3;
	localparam int TICKS_W  = 15;

	// Default duration timer width
	localparam int TIMER_BITS_DEF = 15;

	// Configuration port
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 5;
	localparam int REG_IDX_W = 3;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_CMD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TICK = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MGR  = 2'd2;

	// Beep types
	localparam logic [TYPE_W-1:0] BEEP_SHORT = 2'd0;
	localparam logic [TYPE_W-1:0] BEEP_LONG  = 2'd1;
	localparam logic [TYPE_W-1:0] BEEP_ULTRA = 2'd2;

	// Phase codes
	localparam logic [PHASE_W-1:0] PH_INIT     = 3'd0;
	localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd1;
	localparam logic [PHASE_W-1:0] PH_LOAD     = 3'd2;
	localparam logic [PHASE_W-1:0] PH_ON_WAIT  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_OFF_WAIT = 3'd4;
	localparam logic [PHASE_W-1:0] PH_SINGLE   = 3'd5;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_SHORT_ON  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SHORT_OFF = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_LONG_ON   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_LONG_OFF  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ULTRA_ON  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ULTRA_OFF = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_DISABLE   = 3'd6;

	// Register reset values
	localparam logic [TICKS_W-1:0] RST_SHORT_TICKS = 15'd50;
	localparam logic [TICKS_W-1:0] RST_LONG_TICKS  = 15'd200;
	localparam logic [TICKS_W-1:0] RST_ULTRA_TICKS = 15'd500;

	// One input word as held in the input stage
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [TYPE_W-1:0]  beep_type;
		logic [COUNT_W-1:0] beep_count;
	} bps_item_t;

endpackage

### rtl/core/bps_in_if.sv
// ----------------------------------------------------------------------------
// bps_in_if
// Input channel: beep commands, timer ticks and manager passes.
// ----------------------------------------------------------------------------
interface bps_in_if
	import bps_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [TYPE_W-1:0]  beep_type;
	logic [COUNT_W-1:0] beep_count;

	modport source (output valid, output kind, output beep_type, output beep_count,
		input ready);
	modport sink (input valid, input kind, input beep_type, input beep_count,
		output ready);
endinterface

### rtl/core/bps_out_if.sv
// ----------------------------------------------------------------------------
// bps_out_if
// Result channel: buzzer level and sequencer status after each word.
// ----------------------------------------------------------------------------
interface bps_out_if
	import bps_pkg::*;
;
	logic               valid;
	logic               ready;
	logic               buzzer_on;
	logic [PHASE_W-1:0] phase;
	logic [COUNT_W-1:0] beeps_left;
	logic               burst_pending;

	modport source (output valid, output buzzer_on, output phase, output beeps_left,
		output burst_pending, input ready);
	modport sink (input valid, input buzzer_on, input phase, input beeps_left,
		input burst_pending, output ready);
endinterface

### rtl/core/beep_pattern_sequencer_unit.sv
// ----------------------------------------------------------------------------
// beep_pattern_sequencer_unit
// Buzzer beep burst sequencer: command, tick and manager words in, one
// status word out per input word.
// ----------------------------------------------------------------------------
//
// channel  | direction | handshake      | payload
// ---------+-----------+----------------+-------------------------------------
// item     | in        | valid / ready  | kind, beep_type, beep_count
// result   | out       | valid / ready  | buzzer_on, phase, beeps_left,
//          |           |                | burst_pending
// apb      | in        | psel / penable | paddr, pwdata, pwrite -> prdata
//
// One word per cycle sustained while result.ready stays high.
// A word is captured in the input stage, then decided in one pass against the
// sequencer state, which updates at the same edge as the result register.
// A stalled result holds the input stage; item.ready drops only when both are
// full and result.ready is low.
// arst_n clears the sequencer state, both stage valids and the registers to
// their defaults.
// ----------------------------------------------------------------------------
module beep_pattern_sequencer_unit
	import bps_pkg::*;
#(
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	bps_in_if.sink            item,
	bps_out_if.source         result
);

	// Configuration registers
	logic [TICKS_W-1:0] short_on_q, short_off_q;
	logic [TICKS_W-1:0] long_on_q, long_off_q;
	logic [TICKS_W-1:0] ultra_on_q, ultra_off_q;
	logic               disable_q;

	// Sequencer state
	logic [PHASE_W-1:0]    phase_q, phase_nxt;
	logic                  pending_q, pending_nxt;
	logic [COUNT_W-1:0]    remaining_q, remaining_nxt;
	logic [TYPE_W-1:0]     type_q, type_nxt;
	logic [TIMER_BITS-1:0] timer_q, timer_nxt;
	logic                  pin_q, pin_nxt;

	// Input stage
	bps_item_t item_s1;
	logic      valid_s1;
	logic      advance;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_AW-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_on_q  <= RST_SHORT_TICKS;
			short_off_q <= RST_SHORT_TICKS;
			long_on_q   <= RST_LONG_TICKS;
			long_off_q  <= RST_LONG_TICKS;
			ultra_on_q  <= RST_ULTRA_TICKS;
			ultra_off_q <= RST_ULTRA_TICKS;
			disable_q   <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_SHORT_ON:  short_on_q  <= pwdata[TICKS_W-1:0];
				REG_SHORT_OFF: short_off_q <= pwdata[TICKS_W-1:0];
				REG_LONG_ON:   long_on_q   <= pwdata[TICKS_W-1:0];
				REG_LONG_OFF:  long_off_q  <= pwdata[TICKS_W-1:0];
				REG_ULTRA_ON:  ultra_on_q  <= pwdata[TICKS_W-1:0];
				REG_ULTRA_OFF: ultra_off_q <= pwdata[TICKS_W-1:0];
				REG_DISABLE:   disable_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register read-back
	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_SHORT_ON:  prdata[TICKS_W-1:0] = short_on_q;
			REG_SHORT_OFF: prdata[TICKS_W-1:0] = short_off_q;
			REG_LONG_ON:   prdata[TICKS_W-1:0] = long_on_q;
			REG_LONG_OFF:  prdata[TICKS_W-1:0] = long_off_q;
			REG_ULTRA_ON:  prdata[TICKS_W-1:0] = ultra_on_q;
			REG_ULTRA_OFF: prdata[TICKS_W-1:0] = ultra_off_q;
			REG_DISABLE:   prdata[0]           = disable_q;
			default:       prdata = '0;
		endcase
	end

	// Handshake: input stage moves on whenever the result register is free
	assign advance    = !result.valid || result.ready;
	assign item.ready = !valid_s1 || advance;

	// Capture the input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= '{kind: item.kind, beep_type: item.beep_type,
				beep_count: item.beep_count};
		end
	end

	// Pick a duration for a type; type three keeps the timer as it is
	function automatic logic [TIMER_BITS-1:0] pick_ticks(
		input logic [TYPE_W-1:0]     t,
		input logic                  on_time,
		input logic [TIMER_BITS-1:0] keep,
		input logic [TICKS_W-1:0]    s_on,
		input logic [TICKS_W-1:0]    s_off,
		input logic [TICKS_W-1:0]    l_on,
		input logic [TICKS_W-1:0]    l_off,
		input logic [TICKS_W-1:0]    u_on,
		input logic [TICKS_W-1:0]    u_off
	);
		logic [31:0] wide;
		logic        hit;
		wide = '0;
		hit  = 1'b1;
		case (t)
			BEEP_SHORT: wide[TICKS_W-1:0] = on_time ? s_on : s_off;
			BEEP_LONG:  wide[TICKS_W-1:0] = on_time ? l_on : l_off;
			BEEP_ULTRA: wide[TICKS_W-1:0] = on_time ? u_on : u_off;
			default:    hit = 1'b0;
		endcase
		return hit ? wide[TIMER_BITS-1:0] : keep;
	endfunction

	// Decide the next state for the word in the input stage
	always_comb begin
		phase_nxt     = phase_q;
		pending_nxt   = pending_q;
		remaining_nxt = remaining_q;
		type_nxt      = type_q;
		timer_nxt     = timer_q;
		pin_nxt       = pin_q;
		case (item_s1.kind)
			KIND_CMD: begin
				if (!disable_q) begin
					if (item_s1.beep_count > COUNT_W'(1)) begin
						pending_nxt   = 1'b1;
						remaining_nxt = item_s1.beep_count;
						type_nxt      = item_s1.beep_type;
					end else if (item_s1.beep_count == COUNT_W'(1)) begin
						type_nxt  = item_s1.beep_type;
						pin_nxt   = 1'b1;
						phase_nxt = PH_SINGLE;
						timer_nxt = pick_ticks(item_s1.beep_type, 1'b1, timer_q,
							short_on_q, short_off_q, long_on_q, long_off_q,
							ultra_on_q, ultra_off_q);
					end
				end
			end
			KIND_TICK: begin
				if (timer_q != '0) begin
					timer_nxt = timer_q - TIMER_BITS'(1);
				end
			end
			KIND_MGR: begin
				case (phase_q)
					PH_INIT: phase_nxt = PH_IDLE;
					PH_IDLE: begin
						if (pending_q && remaining_q != '0) begin
							pending_nxt = 1'b0;
							phase_nxt   = PH_LOAD;
						end
					end
					PH_LOAD: begin
						timer_nxt = pick_ticks(type_q, 1'b1, timer_q,
							short_on_q, short_off_q, long_on_q, long_off_q,
							ultra_on_q, ultra_off_q);
						pin_nxt   = 1'b1;
						phase_nxt = PH_ON_WAIT;
					end
					PH_ON_WAIT: begin
						if (timer_q == '0) begin
							timer_nxt = pick_ticks(type_q, 1'b0, timer_q,
								short_on_q, short_off_q, long_on_q, long_off_q,
								ultra_on_q, ultra_off_q);
							pin_nxt   = 1'b0;
							phase_nxt = PH_OFF_WAIT;
						end
					end
					PH_OFF_WAIT: begin
						if (timer_q == '0) begin
							if (remaining_q <= COUNT_W'(1)) begin
								remaining_nxt = '0;
								phase_nxt     = PH_IDLE;
							end else begin
								remaining_nxt = remaining_q - COUNT_W'(1);
								timer_nxt = pick_ticks(type_q, 1'b1, timer_q,
									short_on_q, short_off_q, long_on_q, long_off_q,
									ultra_on_q, ultra_off_q);
								pin_nxt   = 1'b1;
								phase_nxt = PH_ON_WAIT;
							end
						end
					end
					PH_SINGLE: begin
						if (timer_q == '0) begin
							pin_nxt   = 1'b0;
							phase_nxt = PH_IDLE;
						end
					end
					default: phase_nxt = PH_IDLE;
				endcase
			end
			default: ;
		endcase
	end

	// Commit the state and hold the status word for the result channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_INIT;
			pending_q    <= 1'b0;
			remaining_q  <= '0;
			type_q       <= BEEP_SHORT;
			timer_q      <= '0;
			pin_q        <= 1'b0;
			result.valid <= 1'b0;
		end else if (advance) begin
			result.valid <= valid_s1;
			if (valid_s1) begin
				phase_q     <= phase_nxt;
				pending_q   <= pending_nxt;
				remaining_q <= remaining_nxt;
				type_q      <= type_nxt;
				timer_q     <= timer_nxt;
				pin_q       <= pin_nxt;
			end
		end
	end

	assign result.buzzer_on     = pin_q;
	assign result.phase         = phase_q;
	assign result.beeps_left    = remaining_q;
	assign result.burst_pending = pending_q;

	// The pin sounds exactly in the on-wait and single-beep phases
	a_pin_phase: assert property (@(posedge clk) disable iff (!arst_n)
		pin_q == (phase_q == PH_ON_WAIT || phase_q == PH_SINGLE))
		else $error("buzzer level out of step with phase");

	// A running burst always has beeps left
	a_burst_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LOAD || phase_q == PH_ON_WAIT || phase_q == PH_OFF_WAIT)
		|-> remaining_q != '0)
		else $error("burst running with no beeps left");

	// The unreachable phase codes stay unreachable
	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_SINGLE)
		else $error("phase register holds an unused code");

	// A new result only comes from a word held in the input stage
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !valid_s1) |=> !result.valid)
		else $error("result produced without an input word");

endmodule

### verif/beep_pattern_sequencer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beep_pattern_sequencer_unit_tb
// Drives command, tick and manager words into the sequencer through its input
// channel and tracks its own copy of the burst state machine. Each status word
// is checked against that copy. Register settings change between phases over
// the APB port and are read back. The sender and receiver stall at random, and
// one phase holds the result channel off for a long stretch.
// ----------------------------------------------------------------------------
module beep_pattern_sequencer_unit_tb;
	import bps_pkg::*;

	localparam int TMR_W       = TIMER_BITS_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SEG_WORDS   = 112;

	// Codes outside the defined set, still legal on the wires
	localparam logic [KIND_W-1:0]    KIND_NONE    = 2'd3;
	localparam logic [TYPE_W-1:0]    BEEP_UNUSED  = 2'd3;
	localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

	typedef struct packed {
		logic               buzzer_on;
		logic [PHASE_W-1:0] phase;
		logic [COUNT_W-1:0] beeps_left;
		logic               burst_pending;
	} beep_status_t;

	// Tracks the sequencer state and holds the status words still to come
	class buzzer_status_board;
		logic [TICKS_W-1:0] short_on, short_off;
		logic [TICKS_W-1:0] long_on, long_off;
		logic [TICKS_W-1:0] ultra_on, ultra_off;
		logic               muted;
		logic [PHASE_W-1:0] phase;
		logic               pending;
		logic [COUNT_W-1:0] left;
		logic [TYPE_W-1:0]  cur_type;
		logic [TMR_W-1:0]   timer;
		logic               pin;
		beep_status_t       status_due [$];
		int                 errors;

		function new();
			short_on  = RST_SHORT_TICKS;
			short_off = RST_SHORT_TICKS;
			long_on   = RST_LONG_TICKS;
			long_off  = RST_LONG_TICKS;
			ultra_on  = RST_ULTRA_TICKS;
			ultra_off = RST_ULTRA_TICKS;
			muted     = 1'b0;
			phase     = PH_INIT;
			pending   = 1'b0;
			left      = '0;
			cur_type  = BEEP_SHORT;
			timer     = '0;
			pin       = 1'b0;
			errors    = 0;
		endfunction

		function void set_register(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] data);
			case (idx)
				REG_SHORT_ON:  short_on  = data[TICKS_W-1:0];
				REG_SHORT_OFF: short_off = data[TICKS_W-1:0];
				REG_LONG_ON:   long_on   = data[TICKS_W-1:0];
				REG_LONG_OFF:  long_off  = data[TICKS_W-1:0];
				REG_ULTRA_ON:  ultra_on  = data[TICKS_W-1:0];
				REG_ULTRA_OFF: ultra_off = data[TICKS_W-1:0];
				REG_DISABLE:   muted     = data[0];
				default: ;
			endcase
		endfunction

		function logic [APB_DW-1:0] register_value(logic [REG_IDX_W-1:0] idx);
			case (idx)
				REG_SHORT_ON:  return APB_DW'(short_on);
				REG_SHORT_OFF: return APB_DW'(short_off);
				REG_LONG_ON:   return APB_DW'(long_on);
				REG_LONG_OFF:  return APB_DW'(long_off);
				REG_ULTRA_ON:  return APB_DW'(ultra_on);
				REG_ULTRA_OFF: return APB_DW'(ultra_off);
				REG_DISABLE:   return APB_DW'(muted);
				default:       return '0;
			endcase
		endfunction

		// Load the on or off time of a beep type; an unknown type keeps the timer
		function void load_duration(logic [TYPE_W-1:0] bt, bit on_time);
			logic [TICKS_W-1:0] v;
			case (bt)
				BEEP_SHORT: v = on_time ? short_on : short_off;
				BEEP_LONG:  v = on_time ? long_on : long_off;
				BEEP_ULTRA: v = on_time ? ultra_on : ultra_off;
				default:    return;
			endcase
			timer = TMR_W'(v);
		endfunction

		function void run_manager();
			case (phase)
				PH_INIT: phase = PH_IDLE;
				PH_IDLE: begin
					if (pending && left != 0) begin
						pending = 1'b0;
						phase   = PH_LOAD;
					end
				end
				PH_LOAD: begin
					load_duration(cur_type, 1'b1);
					pin   = 1'b1;
					phase = PH_ON_WAIT;
				end
				PH_ON_WAIT: begin
					if (timer == 0) begin
						load_duration(cur_type, 1'b0);
						pin   = 1'b0;
						phase = PH_OFF_WAIT;
					end
				end
				PH_OFF_WAIT: begin
					if (timer == 0) begin
						if (left <= 1) begin
							left  = '0;
							phase = PH_IDLE;
						end else begin
							left = left - 1'b1;
							load_duration(cur_type, 1'b1);
							pin   = 1'b1;
							phase = PH_ON_WAIT;
						end
					end
				end
				PH_SINGLE: begin
					if (timer == 0) begin
						pin   = 1'b0;
						phase = PH_IDLE;
					end
				end
				default: phase = PH_IDLE;
			endcase
		endfunction

		// Apply one accepted word and queue the status it should produce
		function void note_word(logic [KIND_W-1:0] k, logic [TYPE_W-1:0] bt,
			logic [COUNT_W-1:0] cnt);
			case (k)
				KIND_CMD: begin
					if (!muted) begin
						if (cnt > 1) begin
							pending  = 1'b1;
							left     = cnt;
							cur_type = bt;
						end else if (cnt == 1) begin
							cur_type = bt;
							pin      = 1'b1;
							phase    = PH_SINGLE;
							load_duration(cur_type, 1'b1);
						end
					end
				end
				KIND_TICK: begin
					if (timer != 0)
						timer = timer - 1'b1;
				end
				KIND_MGR: run_manager();
				default: ;
			endcase
			status_due.push_back({pin, phase, left, pending});
		endfunction

		function void mismatch(string field, logic [COUNT_W-1:0] want_v,
			logic [COUNT_W-1:0] got_v);
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want_v, got_v);
			errors++;
		endfunction

		function void check_status(beep_status_t got);
			beep_status_t want;
			if (status_due.size() == 0) begin
				$display("%0t: status word with nothing expected: expected none, actual %h",
					$time, got);
				errors++;
				return;
			end
			want = status_due.pop_front();
			if (got.buzzer_on !== want.buzzer_on)
				mismatch("buzzer_on", COUNT_W'(want.buzzer_on), COUNT_W'(got.buzzer_on));
			if (got.phase !== want.phase)
				mismatch("phase", COUNT_W'(want.phase), COUNT_W'(got.phase));
			if (got.beeps_left !== want.beeps_left)
				mismatch("beeps_left", want.beeps_left, got.beeps_left);
			if (got.burst_pending !== want.burst_pending)
				mismatch("burst_pending", COUNT_W'(want.burst_pending),
					COUNT_W'(got.burst_pending));
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	bps_in_if  in_ch ();
	bps_out_if out_ch ();

	buzzer_status_board board;

	int send_idle;
	int recv_idle;
	int hold_req;
	int words_sent;
	int cycle_count;

	beep_pattern_sequencer_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (in_ch),
		.result  (out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog on the whole run
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Note accepted words first, then check the status word taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				board.note_word(in_ch.kind, in_ch.beep_type, in_ch.beep_count);
			if (out_ch.valid && out_ch.ready)
				board.check_status({out_ch.buzzer_on, out_ch.phase, out_ch.beeps_left,
					out_ch.burst_pending});
		end
	end

	// Receiver: random stalls, plus a long hold-off when one is requested
	initial begin
		int hold_left;
		hold_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		board.set_register(idx, data);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_read(input logic [REG_IDX_W-1:0] idx);
		logic [APB_DW-1:0] want;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		want = board.register_value(idx);
		if (prdata !== want) begin
			$display("%0t: register %0d readback mismatch: expected %h, actual %h",
				$time, idx, want, prdata);
			board.errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Offer one word, with random idle cycles first; valid stays high on return
	task automatic send_word(input logic [KIND_W-1:0] k, input logic [TYPE_W-1:0] bt,
		input logic [COUNT_W-1:0] cnt);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.kind       <= k;
		in_ch.beep_type  <= bt;
		in_ch.beep_count <= cnt;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		words_sent++;
	endtask

	task automatic send_tick();
		send_word(KIND_TICK, TYPE_W'($urandom), COUNT_W'($urandom));
	endtask

	task automatic send_pass();
		send_word(KIND_MGR, TYPE_W'($urandom), COUNT_W'($urandom));
	endtask

	// Drop valid and hold until every status word has come back
	task automatic quiesce();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (board.status_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	function automatic logic [COUNT_W-1:0] pick_count();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		else if (r < 45)
			return COUNT_W'(1);
		else if (r < 90)
			return COUNT_W'($urandom_range(6, 2));
		else if (r < 96)
			return COUNT_W'($urandom_range(254, 7));
		return '1;
	endfunction

	task automatic send_noise();
		send_word(KIND_W'($urandom_range(3)), TYPE_W'($urandom_range(3)), pick_count());
	endtask

	// One command followed by a run of ticks and manager passes, lightly salted
	task automatic send_burst_sequence();
		logic [TYPE_W-1:0] bt;
		int                n;
		int                r;
		bt = ($urandom_range(9) == 0) ? BEEP_UNUSED : TYPE_W'($urandom_range(2));
		send_word(KIND_CMD, bt, pick_count());
		n = $urandom_range(24, 4);
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 10)
				send_noise();
			else if (r < 55)
				send_tick();
			else
				send_pass();
		end
	endtask

	// Write a new value to every register per phase, then read every register back
	task automatic apply_setting(input int seg);
		logic [TICKS_W-1:0] ticks;
		logic [APB_DW-1:0]  data;
		int                 r;
		for (int i = 0; i <= int'(REG_ULTRA_OFF); i++) begin
			case (seg)
				1: ticks = '0;
				2: begin
					if (i == int'(REG_LONG_ON) || i == int'(REG_LONG_OFF))
						ticks = '1;
					else
						ticks = TICKS_W'($urandom_range(5));
				end
				4: begin
					r = $urandom_range(99);
					if (r < 20)
						ticks = '1;
					else if (r < 40)
						ticks = '0;
					else
						ticks = TICKS_W'($urandom_range(6));
				end
				default: ticks = TICKS_W'($urandom_range(3));
			endcase
			data = $urandom;
			data[TICKS_W-1:0] = ticks;
			apb_write(REG_IDX_W'(i), data);
		end
		data = $urandom;
		data[0] = (seg == 3);
		apb_write(REG_DISABLE, data);
		if (seg == 3)
			apb_write(REG_UNMAPPED, $urandom);
		for (int i = 0; i <= int'(REG_DISABLE); i++)
			apb_read(REG_IDX_W'(i));
	endtask

	initial begin
		int  target;
		int  midway;
		bit  pressed;
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		in_ch.valid      = 1'b0;
		in_ch.kind       = KIND_CMD;
		in_ch.beep_type  = BEEP_SHORT;
		in_ch.beep_count = '0;
		send_idle        = 33;
		recv_idle        = 64;
		hold_req         = 0;
		words_sent       = 0;
		board            = new();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Short timings but for the ultra on time, so most bursts finish within a handful of words
		apb_write(REG_SHORT_ON, APB_DW'(1));
		apb_write(REG_SHORT_OFF, APB_DW'(0));
		apb_write(REG_LONG_ON, APB_DW'(2));
		apb_write(REG_LONG_OFF, APB_DW'(1));
		apb_write(REG_ULTRA_ON, APB_DW'({TICKS_W{1'b1}}));
		apb_write(REG_ULTRA_OFF, APB_DW'(0));
		apb_write(REG_DISABLE, APB_DW'(0));

		// Directed: unknown kind, init, zero count, single beep of unknown type
		send_word(KIND_NONE, BEEP_UNUSED, '1);
		send_pass();
		send_word(KIND_CMD, BEEP_SHORT, '0);
		send_word(KIND_CMD, BEEP_UNUSED, COUNT_W'(1));
		send_pass();
		// Two-beep burst through load, on-wait and off-wait back to idle
		send_word(KIND_CMD, BEEP_SHORT, COUNT_W'(2));
		send_pass();
		send_pass();
		send_tick();
		send_pass();
		send_pass();
		send_tick();
		send_pass();
		send_pass();
		// Longest single beep, then a maximum-count burst that is only queued, and a new single beep
		send_word(KIND_CMD, BEEP_ULTRA, COUNT_W'(1));
		send_tick();
		send_word(KIND_CMD, BEEP_LONG, '1);
		send_word(KIND_CMD, BEEP_LONG, COUNT_W'(1));
		send_tick();
		send_tick();
		send_pass();
		send_pass();
		send_pass();
		// Commands while disabled
		quiesce();
		apb_write(REG_DISABLE, APB_DW'(1));
		send_word(KIND_CMD, BEEP_SHORT, COUNT_W'(1));
		send_word(KIND_CMD, BEEP_LONG, COUNT_W'(4));

		// Random phases: receiver-heavy idling, sender-heavy idling, then none
		for (int seg = 0; seg < 6; seg++) begin
			quiesce();
			if (seg < 2) begin
				send_idle = 33;
				recv_idle = 64;
			end else if (seg < 4) begin
				send_idle = 64;
				recv_idle = 33;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			apply_setting(seg);
			target  = words_sent + SEG_WORDS;
			midway  = words_sent + SEG_WORDS / 3;
			pressed = 1'b0;
			while (words_sent < target) begin
				if (!pressed && words_sent >= midway) begin
					pressed = 1'b1;
					// Fill the block against a stalled receiver
					if (seg == 4)
						hold_req = 80;
					// Let everything drain before carrying on
					if (seg == 2)
						quiesce();
				end
				send_burst_sequence();
			end
		end

		quiesce();
		repeat (8) @(posedge clk);
		if (board.status_due.size() != 0) begin
			$display("%0t: status words never delivered: expected 0 left, actual %0d",
				$time, board.status_due.size());
			board.errors++;
		end
		if (board.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
